FILE: rtl/av_ts_pkg.sv
// Shared types and constants of the audio/video timestamp interleaver.
package av_ts_pkg;

   localparam int MAX_RESULTS = 32;
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   localparam logic       REQ_PUSH   = 1'b0;
   localparam logic       REQ_DRAIN  = 1'b1;
   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_VIDEO = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef logic signed [63:0] dts_type;

   typedef struct packed {
      logic       req_type;
      logic [1:0] frame_kind;
      logic [31:0] frame_tag;
      dts_type    decode_time;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] out_tag;
      logic        out_is_video;
      dts_type     out_time;
      logic        is_last;
      logic        none_left;
      logic        overflow_drop;
   } rsp_beat_type;

   typedef struct packed {
      logic [31:0] tag;
      dts_type     dts;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSTART,
      ST_AUDIO,
      ST_VIDEO,
      ST_DRAIN
   } state_type;

endpackage

FILE: rtl/av_timestamp_interleaver_top.sv
// Top level of the audio/video timestamp interleaver: two frame FIFOs and the merge sequencer.
// Push: the frame is stored at accept, then tested for a pass in ST_MSTART; without a pass a
//   drop beat, if any, is registered out of ST_MSTART. A pass reads both heads in ST_MSTART,
//   then pops frames in the audio run (ST_AUDIO), then in the video run (ST_VIDEO).
// Each popped frame is held until the next pop or pass end and strobes in the cycle after.
// Drain: one memory read, then the beat from ST_DRAIN; an empty drain is answered from idle.
// Reset (synchronous, active high) empties both FIFOs and clears the seen flags; memory
// contents are not cleared. Result beats are strobed once and cannot be stalled.
module av_timestamp_interleaver_top
   import av_ts_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   output rsp_beat_type rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // FIFO storage: tag and timestamp side by side, one write and one read port each
   entry_type audio_mem [QUEUE_DEPTH];
   entry_type video_mem [QUEUE_DEPTH];

   state_type    state_ff,      state_in;
   logic [IDX_W-1:0] a_head_ff, a_head_in, v_head_ff, v_head_in;
   logic [CNT_W-1:0] a_cnt_ff,  a_cnt_in,  v_cnt_ff,  v_cnt_in;
   logic         seen_a_ff,     seen_a_in;
   logic         seen_v_ff,     seen_v_in;
   logic         merge_ff,      merge_in;
   logic         drop_ff,       drop_in;
   logic         drain_vid_ff,  drain_vid_in;
   logic [NUM_W-1:0] n_ff,      n_in;
   dts_type      lim_ff,        lim_in;
   logic         pend_valid_ff, pend_valid_in;
   rsp_beat_type pend_ff,       pend_in;
   logic         rsp_valid_ff,  rsp_valid_in;
   rsp_beat_type rsp_ff,        rsp_in;
   entry_type    a_rd_ff, v_rd_ff;

   logic             accept;
   logic             a_wr_en, v_wr_en, a_rd_en, v_rd_en;
   logic [IDX_W-1:0] a_tail, v_tail, a_rd_addr, v_rd_addr, a_head_nxt, v_head_nxt;
   logic [SUM_W-1:0] a_tail_sum, v_tail_sum;
   logic             a_le, v_le, room, finish, emit;
   rsp_beat_type     emit_beat;
   entry_type        wr_entry;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Tail slot: head plus fill level, wrapped once
   assign a_tail_sum = SUM_W'(a_head_ff) + SUM_W'(a_cnt_ff);
   assign v_tail_sum = SUM_W'(v_head_ff) + SUM_W'(v_cnt_ff);
   assign a_tail = (a_tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   IDX_W'(a_tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(a_tail_sum);
   assign v_tail = (v_tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   IDX_W'(v_tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(v_tail_sum);
   assign a_head_nxt = (a_head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : a_head_ff + IDX_W'(1);
   assign v_head_nxt = (v_head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : v_head_ff + IDX_W'(1);

   assign wr_entry = '{tag: req_data.frame_tag, dts: req_data.decode_time};

   // Audio head against the video head during the audio run, video head against
   // the latched audio head during the video run; equal times pass the test in either run.
   assign a_le = ($signed(a_rd_ff.dts) <= $signed(v_rd_ff.dts));
   assign v_le = ($signed(v_rd_ff.dts) <= $signed(lim_ff));
   assign room = (n_ff < NUM_W'(MAX_RESULTS));

   always_comb begin
      state_in      = state_ff;
      a_head_in     = a_head_ff;
      v_head_in     = v_head_ff;
      a_cnt_in      = a_cnt_ff;
      v_cnt_in      = v_cnt_ff;
      seen_a_in     = seen_a_ff;
      seen_v_in     = seen_v_ff;
      merge_in      = merge_ff;
      drop_in       = drop_ff;
      drain_vid_in  = drain_vid_ff;
      n_in          = n_ff;
      lim_in        = lim_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      a_wr_en       = 1'b0;
      v_wr_en       = 1'b0;
      a_rd_en       = 1'b0;
      v_rd_en       = 1'b0;
      a_rd_addr     = a_head_ff;
      v_rd_addr     = v_head_ff;
      finish        = 1'b0;
      emit          = 1'b0;
      emit_beat     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_DRAIN) begin
                  // Pop audio first, then video; answer an empty drain at once
                  if (a_cnt_ff != '0) begin
                     a_rd_en      = 1'b1;
                     a_head_in    = a_head_nxt;
                     a_cnt_in     = a_cnt_ff - CNT_W'(1);
                     drain_vid_in = 1'b0;
                     state_in     = ST_DRAIN;
                  end else if (v_cnt_ff != '0) begin
                     v_rd_en      = 1'b1;
                     v_head_in    = v_head_nxt;
                     v_cnt_in     = v_cnt_ff - CNT_W'(1);
                     drain_vid_in = 1'b1;
                     state_in     = ST_DRAIN;
                  end else begin
                     rsp_valid_in     = 1'b1;
                     rsp_in           = '0;
                     rsp_in.none_left = 1'b1;
                     rsp_in.is_last   = 1'b1;
                  end
               end else begin
                  drop_in       = 1'b0;
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  if (req_data.frame_kind == KIND_AUDIO) begin
                     seen_a_in = 1'b1;
                     if (a_cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        a_wr_en  = 1'b1;
                        a_cnt_in = a_cnt_ff + CNT_W'(1);
                     end
                  end else if (req_data.frame_kind == KIND_VIDEO) begin
                     seen_v_in = 1'b1;
                     if (v_cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        v_wr_en  = 1'b1;
                        v_cnt_in = v_cnt_ff + CNT_W'(1);
                     end
                  end
                  merge_in = merge_ff | (seen_a_in & seen_v_in);
                  state_in = ST_MSTART;
               end
            end
         end
         ST_MSTART: begin
            // Fetch both heads once a pass may run
            if (merge_ff && (a_cnt_ff != '0) && (v_cnt_ff != '0)) begin
               a_rd_en  = 1'b1;
               v_rd_en  = 1'b1;
               state_in = ST_AUDIO;
            end else begin
               finish = 1'b1;
            end
         end
         ST_AUDIO: begin
            if (room && (a_cnt_ff != '0) && a_le) begin
               emit                   = 1'b1;
               emit_beat.out_tag      = a_rd_ff.tag;
               emit_beat.out_time     = a_rd_ff.dts;
               emit_beat.overflow_drop = drop_ff;
               a_rd_en                = 1'b1;
               a_rd_addr              = a_head_nxt;
               a_head_in              = a_head_nxt;
               a_cnt_in               = a_cnt_ff - CNT_W'(1);
            end else if (a_cnt_ff != '0) begin
               lim_in   = a_rd_ff.dts;
               state_in = ST_VIDEO;
            end else begin
               finish = 1'b1;
            end
         end
         ST_VIDEO: begin
            if (room && (v_cnt_ff != '0) && v_le) begin
               emit                   = 1'b1;
               emit_beat.out_tag      = v_rd_ff.tag;
               emit_beat.out_is_video = 1'b1;
               emit_beat.out_time     = v_rd_ff.dts;
               emit_beat.overflow_drop = drop_ff;
               v_rd_en                = 1'b1;
               v_rd_addr              = v_head_nxt;
               v_head_in              = v_head_nxt;
               v_cnt_in               = v_cnt_ff - CNT_W'(1);
            end else begin
               finish = 1'b1;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in   = 1'b1;
            rsp_in         = '0;
            rsp_in.is_last = 1'b1;
            if (drain_vid_ff) begin
               rsp_in.out_tag      = v_rd_ff.tag;
               rsp_in.out_is_video = 1'b1;
               rsp_in.out_time     = v_rd_ff.dts;
            end else begin
               rsp_in.out_tag  = a_rd_ff.tag;
               rsp_in.out_time = a_rd_ff.dts;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hold each frame until the next pop or the end of the pass so the last beat can be marked
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_in         = pend_ff;
            rsp_in.is_last = 1'b0;
         end
         pend_in       = emit_beat;
         pend_valid_in = 1'b1;
         n_in          = n_ff + NUM_W'(1);
      end

      if (finish) begin
         state_in      = ST_IDLE;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_in         = pend_ff;
            rsp_in.is_last = 1'b1;
         end else if (drop_ff) begin
            rsp_valid_in               = 1'b1;
            rsp_in                     = '0;
            rsp_in.overflow_drop       = 1'b1;
            rsp_in.is_last             = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         a_head_ff     <= '0;
         v_head_ff     <= '0;
         a_cnt_ff      <= '0;
         v_cnt_ff      <= '0;
         seen_a_ff     <= 1'b0;
         seen_v_ff     <= 1'b0;
         merge_ff      <= 1'b0;
         drop_ff       <= 1'b0;
         drain_vid_ff  <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_head_ff     <= a_head_in;
         v_head_ff     <= v_head_in;
         a_cnt_ff      <= a_cnt_in;
         v_cnt_ff      <= v_cnt_in;
         seen_a_ff     <= seen_a_in;
         seen_v_ff     <= seen_v_in;
         merge_ff      <= merge_in;
         drop_ff       <= drop_in;
         drain_vid_ff  <= drain_vid_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      lim_ff  <= lim_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Audio FIFO memory: registered read, read data held between reads
   always_ff @(posedge clock) begin
      if (a_wr_en) begin
         audio_mem[a_tail] <= wr_entry;
      end
      if (a_rd_en) begin
         a_rd_ff <= audio_mem[a_rd_addr];
      end
   end

   // Video FIFO memory
   always_ff @(posedge clock) begin
      if (v_wr_en) begin
         video_mem[v_tail] <= wr_entry;
      end
      if (v_rd_en) begin
         v_rd_ff <= video_mem[v_rd_addr];
      end
   end

   // Fill levels never pass the FIFO depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (a_cnt_ff <= CNT_W'(QUEUE_DEPTH)) && (v_cnt_ff <= CNT_W'(QUEUE_DEPTH)))
      else $error("FIFO fill level above depth");

   // An empty drain answers with none_left on the next cycle
   empty_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_DRAIN) && (a_cnt_ff == '0) && (v_cnt_ff == '0))
      |=> (rsp_valid_ff && rsp_ff.none_left && rsp_ff.is_last))
      else $error("empty drain not answered");

   // A beat that is not the last of its item leaves the pass still running
   not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.is_last) |-> busy)
      else $error("pass ended without a last beat");

   // A held frame exists only inside a merge run
   pend_in_run: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ((state_ff == ST_AUDIO) || (state_ff == ST_VIDEO)))
      else $error("held frame outside merge run");

endmodule

FILE: tb/sv/frame_merge_scoreboard_pkg.sv
// Scoreboard class: predicts the merged frame beats and checks the strobed results.
package frame_merge_scoreboard_pkg;
   import av_ts_pkg::*;

   class frame_merge_scoreboard;
      int fifo_depth;
      entry_type audio_fifo[$];
      entry_type video_fifo[$];
      bit seen_audio;
      bit seen_video;
      bit merging;
      rsp_beat_type expected_beats[$];
      int mismatches;
      int beats_checked;

      function new(int depth);
         fifo_depth = depth;
         seen_audio = 1'b0;
         seen_video = 1'b0;
         merging = 1'b0;
         mismatches = 0;
         beats_checked = 0;
      endfunction

      function int pending_beats();
         return expected_beats.size();
      endfunction

      // Print one line per fault and count it.
      task report(string what);
         $display("ERROR: %s", what);
         mismatches++;
      endtask

      function void note_request(req_beat_type b);
         rsp_beat_type beats[$];
         rsp_beat_type r;
         entry_type e;
         dts_type bound;
         bit dropped;
         dropped = 1'b0;
         if (b.req_type == REQ_DRAIN) begin
            r = '0;
            r.is_last = 1'b1;
            if (audio_fifo.size() > 0) begin
               e = audio_fifo.pop_front();
               r.out_tag = e.tag;
               r.out_time = e.dts;
            end else if (video_fifo.size() > 0) begin
               e = video_fifo.pop_front();
               r.out_tag = e.tag;
               r.out_time = e.dts;
               r.out_is_video = 1'b1;
            end else begin
               r.none_left = 1'b1;
            end
            expected_beats = {expected_beats, r};
            return;
         end
         e.tag = b.frame_tag;
         e.dts = b.decode_time;
         if (b.frame_kind == KIND_AUDIO) begin
            if (audio_fifo.size() >= fifo_depth)
               dropped = 1'b1;
            else
               audio_fifo = {audio_fifo, e};
            seen_audio = 1'b1;
         end else if (b.frame_kind == KIND_VIDEO) begin
            if (video_fifo.size() >= fifo_depth)
               dropped = 1'b1;
            else
               video_fifo = {video_fifo, e};
            seen_video = 1'b1;
         end
         if (seen_audio && seen_video)
            merging = 1'b1;
         if (merging && audio_fifo.size() > 0 && video_fifo.size() > 0) begin
            // audio first, ties go to audio; then video up to the audio head, ties to video
            bound = video_fifo[0].dts;
            while (beats.size() < MAX_RESULTS && audio_fifo.size() > 0 &&
                   $signed(audio_fifo[0].dts) <= $signed(bound)) begin
               e = audio_fifo.pop_front();
               r = '0;
               r.out_tag = e.tag;
               r.out_time = e.dts;
               r.overflow_drop = dropped;
               beats = {beats, r};
            end
            if (audio_fifo.size() > 0) begin
               bound = audio_fifo[0].dts;
               while (beats.size() < MAX_RESULTS && video_fifo.size() > 0 &&
                      $signed(video_fifo[0].dts) <= $signed(bound)) begin
                  e = video_fifo.pop_front();
                  r = '0;
                  r.out_tag = e.tag;
                  r.out_time = e.dts;
                  r.out_is_video = 1'b1;
                  r.overflow_drop = dropped;
                  beats = {beats, r};
               end
            end
         end
         if (beats.size() == 0 && dropped) begin
            r = '0;
            r.overflow_drop = 1'b1;
            beats = {beats, r};
         end
         if (beats.size() > 0)
            beats[beats.size() - 1].is_last = 1'b1;
         expected_beats = {expected_beats, beats};
      endfunction

      task check_beat(rsp_beat_type got);
         rsp_beat_type want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            report($sformatf("beat %0d: unexpected result, tag %h", beats_checked,
                             got.out_tag));
            return;
         end
         want = expected_beats.pop_front();
         if (got.out_tag !== want.out_tag)
            report($sformatf("beat %0d: out_tag got %h want %h", beats_checked,
                             got.out_tag, want.out_tag));
         if (got.out_is_video !== want.out_is_video)
            report($sformatf("beat %0d: out_is_video got %b want %b", beats_checked,
                             got.out_is_video, want.out_is_video));
         if (got.out_time !== want.out_time)
            report($sformatf("beat %0d: out_time got %h want %h", beats_checked,
                             got.out_time, want.out_time));
         if (got.is_last !== want.is_last)
            report($sformatf("beat %0d: is_last got %b want %b", beats_checked,
                             got.is_last, want.is_last));
         if (got.none_left !== want.none_left)
            report($sformatf("beat %0d: none_left got %b want %b", beats_checked,
                             got.none_left, want.none_left));
         if (got.overflow_drop !== want.overflow_drop)
            report($sformatf("beat %0d: overflow_drop got %b want %b", beats_checked,
                             got.overflow_drop, want.overflow_drop));
      endtask
   endclass

endpackage

FILE: tb/sv/testbench.sv
// Top of the timestamp interleaver testbench: clock, reset, request driver and result monitor.
module testbench;
   import av_ts_pkg::*;
   import frame_merge_scoreboard_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIFO_DEPTH = 16;
   localparam dts_type DTS_MIN = {1'b1, 63'd0};
   localparam dts_type DTS_MAX = {1'b0, {63{1'b1}}};

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_beat_type req_data;
   logic         rsp_valid;
   rsp_beat_type rsp_data;

   frame_merge_scoreboard sb = new(FIFO_DEPTH);

   // Stimulus shaping: a running timestamp and the current traffic mix.
   dts_type time_cursor;
   int      audio_pct;
   int      drain_pct;

   av_timestamp_interleaver_top #(
      .QUEUE_DEPTH(FIFO_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Check every strobed result beat at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_beat(rsp_data);
   end

   // Drop the run if it hangs.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Hold start low with fresh junk on the request bus, n times over; call at a falling edge.
   task automatic hold_off(input int n);
      logic [127:0] junk;
      repeat (n) begin
         junk = {$urandom(), $urandom(), $urandom(), $urandom()};
         start <= 1'b0;
         req_data <= junk[$bits(req_beat_type)-1:0];
         @(negedge clock);
      end
   endtask

   // Present one request beat and hold it until the block takes it; call at a falling edge.
   task automatic send_beat(input req_beat_type b);
      start <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_request(b);
      @(negedge clock);
   endtask

   task automatic issue(input logic req, input logic [1:0] kind, input logic [31:0] tag,
                        input dts_type dts);
      req_beat_type b;
      b.req_type = req;
      b.frame_kind = kind;
      b.frame_tag = tag;
      b.decode_time = dts;
      send_beat(b);
   endtask

   // Pause the sender until every predicted beat has come back.
   task automatic wait_for_quiet();
      while (sb.pending_beats() != 0)
         hold_off(1);
   endtask

   function automatic int draw_gap(input int pct);
      int n;
      n = 0;
      while (n < 40 && $urandom_range(99) < pct)
         n++;
      return n;
   endfunction

   // Pick a new traffic mix: lopsided mixes fill one FIFO and force drops.
   function automatic void pick_mix();
      case ($urandom_range(3))
         0: audio_pct = 10;
         1: audio_pct = 90;
         default: audio_pct = 50;
      endcase
      case ($urandom_range(2))
         0: drain_pct = 3;
         1: drain_pct = 12;
         default: drain_pct = 30;
      endcase
      if ($urandom_range(7) == 0)
         time_cursor = {$urandom(), $urandom()};
   endfunction

   // Mostly frames with close, rising timestamps so the two streams interleave;
   // the rest is drains, kind-none pushes and fully random frames.
   function automatic req_beat_type make_beat();
      req_beat_type b;
      int pick;
      b.req_type = REQ_PUSH;
      b.frame_kind = 2'($urandom_range(3));
      b.frame_tag = $urandom();
      b.decode_time = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < drain_pct) begin
         b.req_type = REQ_DRAIN;
      end else if (pick < drain_pct + 8) begin
         // leave the random kind and timestamp as they are
      end else begin
         time_cursor = time_cursor + 64'($urandom_range(30));
         b.frame_kind = ($urandom_range(99) < audio_pct) ? KIND_AUDIO : KIND_VIDEO;
         b.decode_time = time_cursor + 64'($urandom_range(40)) - 64'd20;
      end
      return b;
   endfunction

   initial begin
      int idle_pct[3];
      idle_pct[0] = 17;
      idle_pct[1] = 78;
      idle_pct[2] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      time_cursor = -64'sd5000;
      audio_pct = 50;
      drain_pct = 10;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      hold_off(2);

      // Directed: empty drain, frames of no media kind, merge held until
      // both kinds are seen, timestamp extremes, equal timestamps.
      issue(REQ_DRAIN, KIND_SPARE, 32'hFFFF_FFFF, DTS_MAX);
      issue(REQ_PUSH, KIND_NONE, 32'h1234_5678, 64'sd7);
      issue(REQ_PUSH, KIND_SPARE, 32'hFFFF_FFFF, DTS_MIN);
      issue(REQ_PUSH, KIND_VIDEO, 32'hFFFF_FFFF, DTS_MAX);
      issue(REQ_PUSH, KIND_AUDIO, 32'h0000_0000, DTS_MIN);
      issue(REQ_PUSH, KIND_AUDIO, 32'hA5A5_5A5A, DTS_MAX);
      issue(REQ_DRAIN, KIND_AUDIO, 32'h0, 64'sd0);
      issue(REQ_DRAIN, KIND_VIDEO, 32'h0, 64'sd0);
      // Fill the audio FIFO with the video side empty, then overflow it.
      for (int i = 0; i <= FIFO_DEPTH; i++)
         issue(REQ_PUSH, KIND_AUDIO, 32'hC000_0000 + 32'(i), 64'sd100 + 64'(i));
      wait_for_quiet();

      // Random: three idle profiles, pausing for all results between them.
      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < 110; i++) begin
            if (i % 30 == 0)
               pick_mix();
            hold_off(draw_gap(idle_pct[phase]));
            send_beat(make_beat());
         end
         wait_for_quiet();
      end

      // Advance until the last beats are in, then allow for a full merge pass.
      hold_off(1);
      while (sb.pending_beats() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (sb.pending_beats() != 0)
         sb.report($sformatf("%0d expected beats never arrived", sb.pending_beats()));
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
rtl/av_ts_pkg.sv
rtl/av_timestamp_interleaver_top.sv
tb/sv/frame_merge_scoreboard_pkg.sv
tb/sv/testbench.sv
